>>> hdl/pfbb_pkg.sv
`default_nettype none

package pfbb_pkg;

    // Item operation codes
    typedef enum logic [1:0] {
        OP_BLIT  = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2
    } op_t;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_DEST_X        = 3'd0,
        CFG_DEST_Y        = 3'd1,
        CFG_ANIM_OFFSET   = 3'd2,
        CFG_CLIP_OFFSET_Y = 3'd3,
        CFG_BLIT_WIDTH    = 3'd4,
        CFG_BLIT_HEIGHT   = 3'd5,
        CFG_INVERT_PIXELS = 3'd6
    } cfg_index_t;

    // Frame store access kinds
    typedef enum logic [1:0] {
        UOP_OR    = 2'd0,
        UOP_CLEAR = 2'd1,
        UOP_READ  = 2'd2
    } uop_kind_t;

    typedef struct packed {
        logic [7:0] dest_x;
        logic [7:0] dest_y;
        logic [7:0] anim_offset;
        logic [7:0] clip_offset_y;
        logic [7:0] blit_width;
        logic [7:0] blit_height;
        logic       invert_pixels;
    } cfg_t;

    typedef struct packed {
        logic      valid;
        uop_kind_t kind;
        logic [7:0] data;
        logic      zero;    // read outside the frame: answer 0
    } uop_t;

    localparam logic [7:0] FULL_MASK   = 8'hFF;
    localparam logic [7:0] PAGE_HEIGHT = 8'd8;
    localparam int         OUT_DEPTH   = 2;

endpackage

`default_nettype wire

>>> hdl/pfbb_channels.sv
`default_nettype none

interface pfbb_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic [7:0] bitmap_byte;
    logic [6:0] column;
    logic [5:0] row_y;

    modport source (output valid, output operation, output bitmap_byte, output column,
                    output row_y, input ready);
    modport sink   (input valid, input operation, input bitmap_byte, input column,
                    input row_y, output ready);
endinterface

interface pfbb_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;

    modport source (output valid, output read_data, input ready);
    modport sink   (input valid, input read_data, output ready);
endinterface

`default_nettype wire

>>> hdl/pfbb_frame_ram.sv
`default_nettype none

module pfbb_frame_ram #(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [7:0]        wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [7:0]        rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    // read returns the old contents on a same-address write
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> hdl/pfbb_out_fifo.sv
`default_nettype none

module pfbb_out_fifo (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    input  wire logic [7:0] push_data,
    output logic      [1:0] count,
    pfbb_out_if.source      results
);

    logic [7:0] entry_reg [pfbb_pkg::OUT_DEPTH];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       pop;

    assign pop           = results.valid && results.ready;
    assign results.valid = (count_reg != 2'd0);
    assign results.read_data = entry_reg[rd_ptr_reg];
    assign count         = count_reg;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

>>> hdl/pfbb_issue.sv
`default_nettype none

module pfbb_issue #(
    parameter int FRAME_COLUMNS = 128,
    parameter int FRAME_ROWS    = 64,
    parameter int ADDR_W        = 10
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              run,
    input  wire pfbb_pkg::cfg_t    cfg,
    input  wire logic              cfg_write,
    input  wire logic              read_credit,
    pfbb_in_if.sink                items,
    output pfbb_pkg::uop_t         uop,
    output logic      [ADDR_W-1:0] uop_addr
);

    localparam int FRAME_PAGES = (FRAME_ROWS + 7) / 8;
    localparam logic [ADDR_W-1:0] COLS_A = ADDR_W'(FRAME_COLUMNS);
    localparam logic [8:0] COLS_9 = 9'(FRAME_COLUMNS);
    localparam logic [8:0] ROWS_9 = 9'(FRAME_ROWS);
    localparam logic [5:0] PAGES_6 = 6'(FRAME_PAGES);

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] pix;
        logic [6:0] col;
        logic [2:0] page;
        logic [7:0] lo;
        logic [7:0] top;
        logic [7:0] bottom;
        logic [7:0] xx;
        logic [2:0] shift;
        logic       clip_on;
        logic       invert;
        logic       blit_en;
    } cmd_t;

    cmd_t       cmd_reg, cmd_next;
    logic       cmd_valid_reg, cmd_valid_next;
    logic       phase_reg, phase_next;
    logic [7:0] col_cursor_reg, col_cursor_next;
    logic [4:0] page_cursor_reg, page_cursor_next;

    logic       accept;
    logic       cmd_done;
    logic [7:0] top_a, y_a, col_step;
    logic [4:0] page_step;
    logic       blit_en_a;

    logic [7:0] hi, k_top, k_bot, mask, px, v_lo, v_hi;
    logic [3:0] rshift;
    logic       skip, col_ok, we_lo, we_hi, in_frame;

    function automatic logic [ADDR_W-1:0] frame_addr(input logic [4:0] pg,
                                                     input logic [7:0] c);
        return ADDR_W'(pg) * COLS_A + ADDR_W'(c);
    endfunction

    // Item intake: cursor snapshot and 8-bit coordinate sums
    always_comb
    begin
        top_a     = cfg.dest_y + cfg.anim_offset;
        y_a       = top_a - cfg.clip_offset_y;
        blit_en_a = (cfg.blit_width != 8'd0) && (cfg.blit_height[7:3] != 5'd0);
        col_step  = col_cursor_reg + 8'd1;
        page_step = page_cursor_reg + 5'd1;

        case (cmd_reg.op)
            pfbb_pkg::OP_BLIT: cmd_done = cmd_valid_reg && phase_reg;
            pfbb_pkg::OP_READ: cmd_done = cmd_valid_reg && read_credit;
            default:           cmd_done = cmd_valid_reg;
        endcase

        items.ready = run && (!cmd_valid_reg || cmd_done);
        accept      = items.valid && items.ready;

        cmd_next = cmd_reg;
        if (accept)
        begin
            cmd_next.op      = items.operation;
            cmd_next.pix     = items.bitmap_byte;
            cmd_next.col     = items.column;
            cmd_next.page    = items.row_y[5:3];
            cmd_next.lo      = {page_cursor_reg, 3'b000} + y_a;
            cmd_next.top     = top_a;
            cmd_next.bottom  = top_a + cfg.blit_height;
            cmd_next.xx      = col_cursor_reg + cfg.dest_x;
            cmd_next.shift   = y_a[2:0];
            cmd_next.clip_on = (cfg.clip_offset_y != 8'd0);
            cmd_next.invert  = cfg.invert_pixels;
            cmd_next.blit_en = blit_en_a;
        end

        cmd_valid_next = accept || (cmd_valid_reg && !cmd_done);
        phase_next     = cmd_valid_reg && (cmd_reg.op == pfbb_pkg::OP_BLIT) && !phase_reg;

        col_cursor_next  = col_cursor_reg;
        page_cursor_next = page_cursor_reg;
        if (cfg_write)
        begin
            col_cursor_next  = 8'd0;
            page_cursor_next = 5'd0;
        end
        else if (accept && (items.operation == pfbb_pkg::OP_BLIT) && blit_en_a)
        begin
            if (col_step >= cfg.blit_width)
            begin
                col_cursor_next  = 8'd0;
                page_cursor_next = (page_step >= cfg.blit_height[7:3]) ? 5'd0 : page_step;
            end
            else
            begin
                col_cursor_next = col_step;
            end
        end
    end

    // Clip, mask and shift of the held command
    always_comb
    begin
        hi    = cmd_reg.lo + pfbb_pkg::PAGE_HEIGHT;
        k_top = cmd_reg.top - cmd_reg.lo;
        k_bot = hi - cmd_reg.bottom;
        skip  = cmd_reg.clip_on && ((hi < cmd_reg.top) || ({1'b0, hi} > ROWS_9)
                                    || (cmd_reg.lo > cmd_reg.bottom));
        mask  = pfbb_pkg::FULL_MASK;
        if (cmd_reg.clip_on && !skip)
        begin
            if (cmd_reg.lo < cmd_reg.top)
            begin
                mask = (k_top >= pfbb_pkg::PAGE_HEIGHT) ? 8'd0
                                                        : pfbb_pkg::FULL_MASK << k_top[2:0];
            end
            else if (hi > cmd_reg.bottom)
            begin
                mask = (k_bot >= pfbb_pkg::PAGE_HEIGHT) ? 8'd0
                                                        : pfbb_pkg::FULL_MASK >> k_bot[2:0];
            end
        end
        px     = (cmd_reg.invert ? ~cmd_reg.pix : cmd_reg.pix) & mask;
        rshift = 4'd8 - {1'b0, cmd_reg.shift};
        v_lo   = px << cmd_reg.shift;
        v_hi   = px >> rshift;
        col_ok = ({1'b0, cmd_reg.xx} < COLS_9);
        we_lo  = cmd_reg.blit_en && !skip && col_ok && ({1'b0, cmd_reg.lo} < ROWS_9);
        we_hi  = cmd_reg.blit_en && !skip && col_ok && (cmd_reg.shift != 3'd0)
                 && ({1'b0, hi} < ROWS_9);
        in_frame = ({2'b0, cmd_reg.col} < COLS_9) && ({3'b0, cmd_reg.page} < PAGES_6);
    end

    // One frame store access per cycle
    always_comb
    begin
        uop.valid = 1'b0;
        uop.kind  = pfbb_pkg::UOP_OR;
        uop.data  = 8'd0;
        uop.zero  = !in_frame;
        uop_addr  = frame_addr({2'b00, cmd_reg.page}, {1'b0, cmd_reg.col});
        case (cmd_reg.op)
            pfbb_pkg::OP_BLIT:
            begin
                uop.valid = cmd_valid_reg && (phase_reg ? we_hi : we_lo);
                uop.data  = phase_reg ? v_hi : v_lo;
                uop_addr  = phase_reg ? frame_addr(hi[7:3], cmd_reg.xx)
                                      : frame_addr(cmd_reg.lo[7:3], cmd_reg.xx);
            end
            pfbb_pkg::OP_READ:
            begin
                uop.valid = cmd_valid_reg && read_credit;
                uop.kind  = pfbb_pkg::UOP_READ;
            end
            pfbb_pkg::OP_CLEAR:
            begin
                uop.valid = cmd_valid_reg && in_frame;
                uop.kind  = pfbb_pkg::UOP_CLEAR;
            end
            default:
            begin
                uop.valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg   <= 1'b0;
            phase_reg       <= 1'b0;
            col_cursor_reg  <= 8'd0;
            page_cursor_reg <= 5'd0;
        end
        else
        begin
            cmd_valid_reg   <= cmd_valid_next;
            phase_reg       <= phase_next;
            col_cursor_reg  <= col_cursor_next;
            page_cursor_reg <= page_cursor_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
    end

endmodule

`default_nettype wire

>>> hdl/page_framebuffer_bitmap_blit_top.sv
`default_nettype none

// Page-mode framebuffer blitter. The frame store is FRAME_COLUMNS x FRAME_ROWS
// pixels held as column bytes (bit 0 on top), one byte per column per page of
// eight rows, in a synchronous RAM with one write and one read port. Beats on
// items are blits (next bitmap byte, ORed in at the cursor position), reads
// (one beat on results) or clears of one byte. A blit beat does one
// read-modify-write of the frame store per destination page; read and clear
// beats make one access. Back-to-back accesses to the same byte are forwarded,
// so no mix of beats stalls for a hazard. Reads are held back while the
// two-deep result queue, counting a read still in the RAM stage, has no room;
// a slot only counts as free once its beat has left, so even an unbroken run
// of reads with results taken straight away is held back at times. With an
// idle pipe a read passes the command register, the RAM stage and the result
// queue to the result beat. After reset the frame store is cleared one byte
// per cycle, FRAME_COLUMNS * ceil(FRAME_ROWS / 8) bytes, 1024 at the defaults;
// items are not taken until then, configuration writes are. The user must
// write configuration only with the block idle; the block does not enforce
// it. Any write to a register rewinds the bitmap cursor to its first byte.

module page_framebuffer_bitmap_blit_top #(
    parameter int FRAME_COLUMNS = 128,
    parameter int FRAME_ROWS    = 64
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic [2:0] cfg_index,
    input  wire logic [7:0] cfg_data,
    pfbb_in_if.sink         items,
    pfbb_out_if.source      results
);

    localparam int FRAME_PAGES = (FRAME_ROWS + 7) / 8;
    localparam int DEPTH       = FRAME_COLUMNS * FRAME_PAGES;
    localparam int ADDR_W      = $clog2(DEPTH);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
    localparam logic [ADDR_W-1:0] ADDR_ONE  = ADDR_W'(1);

    // configuration registers
    pfbb_pkg::cfg_t cfg_reg, cfg_next;
    logic           cfg_write;

    // clearing pass
    logic [ADDR_W-1:0] clr_addr_reg, clr_addr_next;
    logic              clr_done_reg, clr_done_next;

    // access issued this cycle, and the one at the RAM output
    pfbb_pkg::uop_t    uop;
    logic [ADDR_W-1:0] uop_addr;
    pfbb_pkg::uop_t    uop_reg;
    logic [ADDR_W-1:0] uop_addr_reg;

    // last write, forwarded to a read that raced it
    logic              last_wr_valid_reg, last_wr_valid_next;
    logic [ADDR_W-1:0] last_addr_reg;
    logic [7:0]        last_data_reg;

    logic [7:0]        rdata, old_byte;
    logic              acc_we;
    logic [7:0]        acc_wdata;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [7:0]        ram_wdata;
    logic              push;
    logic [7:0]        push_data;
    logic [1:0]        fifo_count;
    logic              read_credit;

    always_comb
    begin
        cfg_next  = cfg_reg;
        cfg_write = 1'b0;
        if (cfg_we)
        begin
            cfg_write = 1'b1;
            case (pfbb_pkg::cfg_index_t'(cfg_index))
                pfbb_pkg::CFG_DEST_X:        cfg_next.dest_x        = cfg_data;
                pfbb_pkg::CFG_DEST_Y:        cfg_next.dest_y        = cfg_data;
                pfbb_pkg::CFG_ANIM_OFFSET:   cfg_next.anim_offset   = cfg_data;
                pfbb_pkg::CFG_CLIP_OFFSET_Y: cfg_next.clip_offset_y = cfg_data;
                pfbb_pkg::CFG_BLIT_WIDTH:    cfg_next.blit_width    = cfg_data;
                pfbb_pkg::CFG_BLIT_HEIGHT:   cfg_next.blit_height   = cfg_data;
                pfbb_pkg::CFG_INVERT_PIXELS: cfg_next.invert_pixels = cfg_data[0];
                default:                     cfg_write              = 1'b0;
            endcase
        end
    end

    always_comb
    begin
        clr_done_next = clr_done_reg || (clr_addr_reg == LAST_ADDR);
        clr_addr_next = clr_done_reg ? clr_addr_reg : clr_addr_reg + ADDR_ONE;
    end

    // a result may issue only if the queue will have a slot for it
    assign read_credit = ((fifo_count + {1'b0, uop_reg.valid
                          && (uop_reg.kind == pfbb_pkg::UOP_READ)})
                          < 2'(pfbb_pkg::OUT_DEPTH));

    pfbb_issue #(
        .FRAME_COLUMNS (FRAME_COLUMNS),
        .FRAME_ROWS    (FRAME_ROWS),
        .ADDR_W        (ADDR_W)
    ) u_issue (
        .clk         (clk),
        .rst_n       (rst_n),
        .run         (clr_done_reg),
        .cfg         (cfg_reg),
        .cfg_write   (cfg_write),
        .read_credit (read_credit),
        .items       (items),
        .uop         (uop),
        .uop_addr    (uop_addr)
    );

    pfbb_frame_ram #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (uop.valid),
        .raddr (uop_addr),
        .rdata (rdata)
    );

    // modify stage: the RAM read came back, merge and write it
    always_comb
    begin
        old_byte = (last_wr_valid_reg && (last_addr_reg == uop_addr_reg))
                   ? last_data_reg : rdata;
        acc_we    = 1'b0;
        acc_wdata = 8'd0;
        push      = 1'b0;
        push_data = uop_reg.zero ? 8'd0 : old_byte;
        if (uop_reg.valid)
        begin
            case (uop_reg.kind)
                pfbb_pkg::UOP_OR:
                begin
                    acc_we    = 1'b1;
                    acc_wdata = old_byte | uop_reg.data;
                end
                pfbb_pkg::UOP_CLEAR:
                begin
                    acc_we = 1'b1;
                end
                pfbb_pkg::UOP_READ:
                begin
                    push = 1'b1;
                end
                default:
                begin
                    acc_we = 1'b0;
                end
            endcase
        end
        last_wr_valid_next = acc_we;

        // the clearing pass owns the write port until it is done
        ram_we    = clr_done_reg ? acc_we : 1'b1;
        ram_waddr = clr_done_reg ? uop_addr_reg : clr_addr_reg;
        ram_wdata = clr_done_reg ? acc_wdata : 8'd0;
    end

    pfbb_out_fifo u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .count     (fifo_count),
        .results   (results)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg           <= '0;
            clr_addr_reg      <= '0;
            clr_done_reg      <= 1'b0;
            uop_reg           <= '0;
            last_wr_valid_reg <= 1'b0;
        end
        else
        begin
            cfg_reg           <= cfg_next;
            clr_addr_reg      <= clr_addr_next;
            clr_done_reg      <= clr_done_next;
            uop_reg           <= uop;
            last_wr_valid_reg <= last_wr_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        uop_addr_reg  <= uop_addr;
        last_addr_reg <= uop_addr_reg;
        last_data_reg <= acc_wdata;
    end

endmodule

`default_nettype wire

>>> sim/pfbb_frame_checker.sv
`timescale 1ns / 1ps

// Watches the config port and both channels, keeps its own copy of the frame
// and the bitmap cursor, and scores every read_data beat against the oldest
// outstanding read.
module pfbb_frame_checker #(
    parameter int FRAME_COLUMNS = 128,
    parameter int FRAME_ROWS    = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [2:0] cfg_index,
    input  logic [7:0] cfg_data,
    pfbb_in_if         items,
    pfbb_out_if        results,
    output int         fail_count,
    output int         reads_pending
);

    localparam int FRAME_PAGES = (FRAME_ROWS + 7) / 8;
    localparam int FRAME_BYTES = FRAME_COLUMNS * FRAME_PAGES;

    logic [7:0]      frame_bytes [FRAME_BYTES];
    logic [7:0]      bmp_column;
    logic [4:0]      bmp_page;
    pfbb_pkg::cfg_t  regs;
    logic [7:0]      read_bytes_due [$];

    task automatic report_mismatch(input string what);
        fail_count++;
        $display("[%0t] MISMATCH %s", $time, what);
    endtask

    // OR one bitmap byte into the frame at the cursor, then step the cursor
    task automatic blit_into_frame(input logic [7:0] raw);
        int unsigned page_rows, top_row, y0, shift, bottom_row, lo, hi, xx, k;
        logic [7:0]  mask, px, upper_part, lower_part;
        bit          skip;
        page_rows  = regs.blit_height / pfbb_pkg::PAGE_HEIGHT;
        top_row    = (regs.dest_y + regs.anim_offset) & 32'hFF;
        y0         = (top_row - regs.clip_offset_y) & 32'hFF;
        shift      = y0 & 7;
        bottom_row = (top_row + regs.blit_height) & 32'hFF;
        lo         = (bmp_page * 8 + y0) & 32'hFF;
        hi         = (lo + 8) & 32'hFF;
        xx         = (bmp_column + regs.dest_x) & 32'hFF;
        mask       = pfbb_pkg::FULL_MASK;
        skip       = 1'b0;
        // clip window only applies with a nonzero scroll offset
        if (regs.clip_offset_y != 0)
        begin
            if (hi < top_row || hi > FRAME_ROWS || lo > bottom_row)
                skip = 1'b1;
            else if (lo < top_row)
            begin
                k    = top_row - lo;
                mask = (k >= 8) ? 8'h00 : 8'(pfbb_pkg::FULL_MASK << k);
            end
            else if (hi > bottom_row)
            begin
                k    = hi - bottom_row;
                mask = (k >= 8) ? 8'h00 : 8'(pfbb_pkg::FULL_MASK >> k);
            end
        end
        if (!skip && xx < FRAME_COLUMNS)
        begin
            px         = (regs.invert_pixels ? ~raw : raw) & mask;
            upper_part = px << shift;
            lower_part = px >> (8 - shift);
            if (lo < FRAME_ROWS)
                frame_bytes[(lo / 8) * FRAME_COLUMNS + xx] |= upper_part;
            if (shift != 0 && hi < FRAME_ROWS)
                frame_bytes[(hi / 8) * FRAME_COLUMNS + xx] |= lower_part;
        end
        bmp_column = bmp_column + 8'd1;
        if (bmp_column >= regs.blit_width)
        begin
            bmp_column = '0;
            bmp_page   = bmp_page + 5'd1;
            if (bmp_page >= page_rows)
                bmp_page = '0;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        logic [7:0]  due;
        int unsigned byte_at;
        bit          in_frame;
        bit          rewind;
        if (!rst_n)
        begin
            for (int i = 0; i < FRAME_BYTES; i++)
                frame_bytes[i] = '0;
            bmp_column = '0;
            bmp_page   = '0;
            regs       = '0;
            read_bytes_due.delete();
            fail_count    = 0;
            reads_pending = 0;
        end
        else
        begin
            // a result beat here always belongs to an earlier read
            if (results.valid && results.ready)
            begin
                if (read_bytes_due.size() == 0)
                    report_mismatch($sformatf("read_data 0x%02h with no read outstanding",
                                              results.read_data));
                else
                begin
                    due = read_bytes_due.pop_front();
                    if (results.read_data !== due)
                        report_mismatch($sformatf("read_data got 0x%02h want 0x%02h",
                                                  results.read_data, due));
                end
            end

            if (cfg_we)
            begin
                rewind = 1'b1;
                case (cfg_index)
                    pfbb_pkg::CFG_DEST_X:        regs.dest_x        = cfg_data;
                    pfbb_pkg::CFG_DEST_Y:        regs.dest_y        = cfg_data;
                    pfbb_pkg::CFG_ANIM_OFFSET:   regs.anim_offset   = cfg_data;
                    pfbb_pkg::CFG_CLIP_OFFSET_Y: regs.clip_offset_y = cfg_data;
                    pfbb_pkg::CFG_BLIT_WIDTH:    regs.blit_width    = cfg_data;
                    pfbb_pkg::CFG_BLIT_HEIGHT:   regs.blit_height   = cfg_data;
                    pfbb_pkg::CFG_INVERT_PIXELS: regs.invert_pixels = cfg_data[0];
                    default:                     rewind = 1'b0;
                endcase
                if (rewind)
                begin
                    bmp_column = '0;
                    bmp_page   = '0;
                end
            end

            if (items.valid && items.ready)
            begin
                byte_at  = (items.row_y / 8) * FRAME_COLUMNS + items.column;
                in_frame = (items.column < FRAME_COLUMNS) && (items.row_y / 8 < FRAME_PAGES);
                case (items.operation)
                    pfbb_pkg::OP_BLIT:
                        if (regs.blit_width != 0 && regs.blit_height >= pfbb_pkg::PAGE_HEIGHT)
                            blit_into_frame(items.bitmap_byte);
                    pfbb_pkg::OP_READ:
                        read_bytes_due.push_back(in_frame ? frame_bytes[byte_at] : 8'h00);
                    pfbb_pkg::OP_CLEAR:
                        if (in_frame)
                            frame_bytes[byte_at] = '0;
                    default: ;
                endcase
            end
            reads_pending = read_bytes_due.size();
        end
    end

endmodule

>>> sim/tb_page_framebuffer_bitmap_blit_top.sv
`timescale 1ns / 1ps

module tb_page_framebuffer_bitmap_blit_top;

    localparam int         FRAME_COLUMNS   = 128;
    localparam int         FRAME_ROWS      = 64;
    localparam logic [1:0] OP_UNUSED       = 2'd3;   // spare op code, block ignores it
    localparam int         SETTLE_CYCLES   = 8;      // covers blit RMW and the read pipe
    localparam int         HOLD_CYCLES     = 300;    // long receiver back-pressure stretch
    localparam int         WATCHDOG_LIMIT  = 4000;   // covers the clearing pass plus the hold
    localparam int         ITEMS_PER_PHASE = 300;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [7:0]  cfg_data;

    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    bit          hold_request  = 1'b0;
    int unsigned items_sent    = 0;
    int unsigned stalled_cycles;
    int          chk_failures;
    int          chk_pending;

    pfbb_in_if  items_ch ();
    pfbb_out_if results_ch ();

    page_framebuffer_bitmap_blit_top #(
        .FRAME_COLUMNS (FRAME_COLUMNS),
        .FRAME_ROWS    (FRAME_ROWS)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .items     (items_ch),
        .results   (results_ch)
    );

    pfbb_frame_checker #(
        .FRAME_COLUMNS (FRAME_COLUMNS),
        .FRAME_ROWS    (FRAME_ROWS)
    ) u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .items         (items_ch),
        .results       (results_ch),
        .fail_count    (chk_failures),
        .reads_pending (chk_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Offer one beat on items, idling first at the current sender rate.
    // Junk goes on the payload while valid is low. Returns on the accepting
    // edge with valid still high, so back-to-back beats never drop valid.
    task automatic send_item(input logic [1:0] op, input logic [7:0] bits,
                             input logic [6:0] col, input logic [5:0] row);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            items_ch.valid       <= 1'b0;
            items_ch.operation   <= 2'($urandom);
            items_ch.bitmap_byte <= 8'($urandom);
            items_ch.column      <= 7'($urandom);
            items_ch.row_y       <= 6'($urandom);
            @(posedge clk);
        end
        items_ch.valid       <= 1'b1;
        items_ch.operation   <= op;
        items_ch.bitmap_byte <= bits;
        items_ch.column      <= col;
        items_ch.row_y       <= row;
        @(posedge clk);
        while (!items_ch.ready)
            @(posedge clk);
        if (op != OP_UNUSED)
            items_sent++;
    endtask

    // Drop valid, wait for every outstanding read to come back, then give
    // any blit still in its read-modify-write time to land.
    task automatic drain_and_settle();
        items_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (chk_pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input pfbb_pkg::cfg_index_t idx, input logic [7:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
    endtask

    // Writes every register; the last write also rewinds the bitmap cursor.
    // Upper bits of the invert write are junk: only bit 0 counts.
    task automatic load_settings(input pfbb_pkg::cfg_t s);
        write_reg(pfbb_pkg::CFG_DEST_X, s.dest_x);
        write_reg(pfbb_pkg::CFG_DEST_Y, s.dest_y);
        write_reg(pfbb_pkg::CFG_ANIM_OFFSET, s.anim_offset);
        write_reg(pfbb_pkg::CFG_CLIP_OFFSET_Y, s.clip_offset_y);
        write_reg(pfbb_pkg::CFG_BLIT_WIDTH, s.blit_width);
        write_reg(pfbb_pkg::CFG_BLIT_HEIGHT, s.blit_height);
        write_reg(pfbb_pkg::CFG_INVERT_PIXELS, {7'($urandom), s.invert_pixels});
        cfg_we <= 1'b0;
    endtask

    function automatic pfbb_pkg::cfg_t make_settings(input logic [7:0] x,
                                                     input logic [7:0] y,
                                                     input logic [7:0] anim,
                                                     input logic [7:0] clip,
                                                     input logic [7:0] w,
                                                     input logic [7:0] h,
                                                     input logic inv);
        pfbb_pkg::cfg_t s;
        s.dest_x        = x;
        s.dest_y        = y;
        s.anim_offset   = anim;
        s.clip_offset_y = clip;
        s.blit_width    = w;
        s.blit_height   = h;
        s.invert_pixels = inv;
        return s;
    endfunction

    // kind 0: small random bitmap somewhere near the frame
    // kind 1: everything at its top value; kind 2: everything zero
    // kind 3: widest bitmap, one page row; kind 4: one column, tallest bitmap
    function automatic pfbb_pkg::cfg_t pick_settings(input int unsigned kind);
        pfbb_pkg::cfg_t s;
        s = make_settings(($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 127)),
                          ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 63)),
                          ($urandom_range(0, 2) == 0) ? 8'($urandom) : 8'($urandom_range(0, 15)),
                          ($urandom_range(0, 1) == 0) ? 8'h00 : 8'($urandom_range(1, 24)),
                          8'($urandom_range(1, 12)),
                          8'($urandom_range(8, 40)),
                          1'($urandom));
        case (kind)
            1: s = make_settings(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1);
            2: s = '0;
            3:
            begin
                s.blit_width  = 8'hFF;
                s.blit_height = 8'd8;
            end
            4:
            begin
                s.blit_width    = 8'd1;
                s.blit_height   = 8'hFF;
                s.clip_offset_y = 8'($urandom_range(1, 255));
            end
            default: ;
        endcase
        return s;
    endfunction

    // One well-formed pass: clear a patch under the bitmap, stream its bytes,
    // read the patch back, then a little noise (any op, spare code included).
    task automatic run_scene(input pfbb_pkg::cfg_t s);
        int unsigned full_bytes, n_blit;
        logic [7:0]  bits;
        repeat ($urandom_range(4, 16))
            send_item(pfbb_pkg::OP_CLEAR, 8'($urandom),
                      7'(s.dest_x + $urandom_range(0, s.blit_width)), 6'($urandom));
        full_bytes = s.blit_width * (s.blit_height / 8);
        if (full_bytes == 0)
            n_blit = $urandom_range(1, 4);
        else if (full_bytes <= 40 && $urandom_range(0, 2) != 0)
            n_blit = full_bytes;
        else
            n_blit = $urandom_range(1, (full_bytes < 40) ? full_bytes : 40);
        repeat (n_blit)
        begin
            case ($urandom_range(0, 7))
                0:       bits = 8'h00;
                1:       bits = 8'hFF;
                default: bits = 8'($urandom);
            endcase
            send_item(pfbb_pkg::OP_BLIT, bits, 7'($urandom), 6'($urandom));
        end
        repeat ($urandom_range(6, 16))
        begin
            if ($urandom_range(0, 3) == 0)
                send_item(pfbb_pkg::OP_READ, 8'($urandom), 7'($urandom), 6'($urandom));
            else
                send_item(pfbb_pkg::OP_READ, 8'($urandom),
                          7'(s.dest_x + $urandom_range(0, s.blit_width)), 6'($urandom));
        end
        repeat ($urandom_range(0, 3))
            send_item(2'($urandom), 8'($urandom), 7'($urandom), 6'($urandom));
    endtask

    // Result side: random stalls at the current rate, or one long hold when
    // asked, counted here so the sender keeps pushing meanwhile.
    initial
    begin
        results_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                results_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
                results_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Watchdog: too long without a beat on either channel ends the run
    initial
    begin
        stalled_cycles = 0;
        while (stalled_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((items_ch.valid && items_ch.ready) || (results_ch.valid && results_ch.ready))
                stalled_cycles = 0;
            else
                stalled_cycles++;
        end
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        pfbb_pkg::cfg_t s;
        int unsigned    phase_start;
        int unsigned    round_no;
        rst_n                = 1'b0;
        cfg_we               <= 1'b0;
        cfg_index            <= pfbb_pkg::CFG_DEST_X;
        cfg_data             <= 8'h00;
        items_ch.valid       <= 1'b0;
        items_ch.operation   <= pfbb_pkg::OP_BLIT;
        items_ch.bitmap_byte <= 8'h00;
        items_ch.column      <= 7'd0;
        items_ch.row_y       <= 6'd0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // --- directed ---
        // registers still at reset: blits are empty; frame reads back as zero
        // (first beat waits out the clearing pass)
        send_item(pfbb_pkg::OP_BLIT, 8'hFF, 7'd0, 6'd0);
        send_item(pfbb_pkg::OP_READ, 8'h00, 7'd0, 6'd0);
        send_item(pfbb_pkg::OP_READ, 8'hFF, 7'd127, 6'd63);
        send_item(OP_UNUSED, 8'hA5, 7'd5, 6'd9);
        send_item(pfbb_pkg::OP_CLEAR, 8'h00, 7'd127, 6'd63);

        // 2 x 2 bitmap at the origin: cursor wraps back, fifth byte ORs over first
        drain_and_settle();
        load_settings(make_settings(8'd0, 8'd0, 8'd0, 8'd0, 8'd2, 8'd16, 1'b0));
        send_item(pfbb_pkg::OP_BLIT, 8'hFF, 7'd0, 6'd0);
        send_item(pfbb_pkg::OP_BLIT, 8'h00, 7'd0, 6'd0);
        send_item(pfbb_pkg::OP_BLIT, 8'h81, 7'd0, 6'd0);
        send_item(pfbb_pkg::OP_BLIT, 8'h5A, 7'd0, 6'd0);
        send_item(pfbb_pkg::OP_BLIT, 8'h3C, 7'd0, 6'd0);
        send_item(pfbb_pkg::OP_READ, 8'h00, 7'd0, 6'd0);
        send_item(pfbb_pkg::OP_READ, 8'h00, 7'd1, 6'd0);
        send_item(pfbb_pkg::OP_READ, 8'h00, 7'd0, 6'd8);
        send_item(pfbb_pkg::OP_READ, 8'h00, 7'd1, 6'd8);

        // right edge and vertical wrap: row 253 spills over into page 0,
        // second column lands past the frame and is dropped
        drain_and_settle();
        load_settings(make_settings(8'd127, 8'd250, 8'd3, 8'd0, 8'd2, 8'd8, 1'b0));
        send_item(pfbb_pkg::OP_BLIT, 8'hFF, 7'd0, 6'd0);
        send_item(pfbb_pkg::OP_BLIT, 8'hFF, 7'd0, 6'd0);
        send_item(pfbb_pkg::OP_READ, 8'h00, 7'd127, 6'd0);

        // clip window with inverted pixels: top page masked
        drain_and_settle();
        load_settings(make_settings(8'd4, 8'd20, 8'd0, 8'd4, 8'd1, 8'd16, 1'b1));
        send_item(pfbb_pkg::OP_BLIT, 8'h0F, 7'd0, 6'd0);
        send_item(pfbb_pkg::OP_BLIT, 8'hF0, 7'd0, 6'd0);
        send_item(pfbb_pkg::OP_READ, 8'h00, 7'd4, 6'd16);
        send_item(pfbb_pkg::OP_READ, 8'h00, 7'd4, 6'd24);
        send_item(pfbb_pkg::OP_READ, 8'h00, 7'd4, 6'd32);

        // --- random, three idling regimes ---
        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 33;
                    recv_idle_pct = 70;
                end
                1:
                begin
                    send_idle_pct = 70;
                    recv_idle_pct = 33;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            phase_start = items_sent;
            round_no    = 0;
            while (items_sent - phase_start < ITEMS_PER_PHASE)
            begin
                drain_and_settle();
                if (round_no == 0)
                    s = pick_settings(phase + 1);
                else if (phase == 0 && round_no == 1)
                    s = pick_settings(4);
                else
                    s = pick_settings(0);
                load_settings(s);
                // back-pressure: result side holds off while reads keep
                // coming, so the result queue fills and items stalls
                if (phase == 2 && round_no == 1)
                begin
                    hold_request = 1'b1;
                    repeat (40)
                        send_item(pfbb_pkg::OP_READ, 8'($urandom), 7'($urandom),
                                  6'($urandom));
                end
                run_scene(s);
                run_scene(s);
                round_no++;
            end
        end

        drain_and_settle();
        if (chk_failures == 0 && chk_pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

>>> files.f
hdl/pfbb_pkg.sv
hdl/pfbb_channels.sv
hdl/pfbb_frame_ram.sv
hdl/pfbb_out_fifo.sv
hdl/pfbb_issue.sv
hdl/page_framebuffer_bitmap_blit_top.sv
sim/pfbb_frame_checker.sv
sim/tb_page_framebuffer_bitmap_blit_top.sv
